>>> rtl/svt_pkg.sv
// Shared types, codes and helpers for the sorted value table.
`default_nettype none

package svt_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int TALLY_W       = 5;

  typedef logic [2:0]         func_t;
  typedef logic signed [31:0] value_t;
  typedef logic [1:0]         status_t;
  typedef logic [TALLY_W-1:0] tally_t;

  localparam func_t FUNC_INSERT = 3'd0;
  localparam func_t FUNC_REMOVE = 3'd1;
  localparam func_t FUNC_SEARCH = 3'd2;
  localparam func_t FUNC_DUMP   = 3'd3;
  localparam func_t FUNC_COUNT  = 3'd4;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  typedef struct packed {
    status_t status;
    logic    found;
    value_t  entry;
    tally_t  tally;
    logic    last;
  } svt_res_t;

  function automatic svt_res_t make_res(status_t s, logic f, value_t e, tally_t t, logic l);
    svt_res_t r;
    r.status = s;
    r.found  = f;
    r.entry  = e;
    r.tally  = t;
    r.last   = l;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/svt_req_if.sv
// Request channel: operation code and operand.
`default_nettype none

interface svt_req_if;
  import svt_pkg::*;

  logic   valid;
  logic   ready;
  func_t  func;
  value_t value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

`default_nettype wire

>>> rtl/svt_rsp_if.sv
// Result channel: status, search flag, dumped entry, tally and last marker.
`default_nettype none

interface svt_rsp_if;
  import svt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    found;
  value_t  entry;
  tally_t  tally;
  logic    last;

  modport source (output valid, status, found, entry, tally, last, input ready);
  modport sink   (input valid, status, found, entry, tally, last, output ready);
endinterface

`default_nettype wire

>>> rtl/svt_mem.sv
// Entry storage: one write port, one read port with registered, held read data.
`default_nettype none

module svt_mem #(
  parameter int DEPTH = svt_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  svt_pkg::value_t                        wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output svt_pkg::value_t                        rd_data
);
  import svt_pkg::*;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/svt_seq.sv
// Operation sequencer: scans the entry memory one address per cycle, pausing a dump while the result side stalls.
`default_nettype none

module svt_seq #(
  parameter int DEPTH = svt_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  svt_pkg::func_t                         req_func,
  input  svt_pkg::value_t                        req_value,
  output logic                                   rd_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  svt_pkg::value_t                        rd_data,
  output logic                                   wr_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output svt_pkg::value_t                        wr_data,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output svt_pkg::svt_res_t                      res
);
  import svt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_INS0 = 3'd2;
  localparam logic [2:0] S_UP   = 3'd3;
  localparam logic [2:0] S_DUMP = 3'd4;
  localparam logic [2:0] S_SEND = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] occ, occ_next;
  logic [CW-1:0] dpos, dpos_next;   // address of the data now on rd_data
  logic [CW-1:0] idx, idx_next;     // next dump address to read
  logic [CW-1:0] evens, evens_next;
  logic          pend, pend_next;   // dump: rd_data holds an entry not yet sent
  logic          hit, hit_next;
  func_t         op, op_next;
  value_t        val, val_next;
  svt_res_t      res_q, res_q_next;

  always_comb begin
    logic          hit_n;
    logic [CW-1:0] evens_n;
    logic          can_load;
    logic          issue;

    state_next = state;
    occ_next   = occ;
    dpos_next  = dpos;
    idx_next   = idx;
    evens_next = evens;
    pend_next  = pend;
    hit_next   = hit;
    op_next    = op;
    val_next   = val;
    res_q_next = res_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = val;
    hit_n      = hit | (rd_data == val);
    evens_n    = evens + CW'(!rd_data[0]);
    can_load   = pend && res_ready;
    issue      = (idx < occ) && (!pend || can_load);

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next    = req_func;
          val_next   = req_value;
          hit_next   = 1'b0;
          evens_next = '0;
          pend_next  = 1'b0;
          case (req_func)
            FUNC_INSERT: begin
              if (occ == CW'(DEPTH)) begin
                res_q_next = make_res(ST_FULL, 1'b0, '0, TALLY_W'(occ), 1'b1);
                state_next = S_SEND;
              end else if (occ == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = req_value;
                occ_next   = CW'(1);
                res_q_next = make_res(ST_EMPTY, 1'b0, '0, TALLY_W'(1), 1'b1);
                state_next = S_SEND;
              end else begin
                // walk down from the tail, shifting larger entries up by one
                rd_en      = 1'b1;
                rd_addr    = AW'(occ - 1'b1);
                dpos_next  = occ - 1'b1;
                state_next = S_INS;
              end
            end
            FUNC_REMOVE, FUNC_SEARCH, FUNC_COUNT: begin
              if (occ == '0) begin
                res_q_next = make_res(ST_EMPTY, 1'b0, '0, '0, 1'b1);
                state_next = S_SEND;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                dpos_next  = '0;
                state_next = S_UP;
              end
            end
            FUNC_DUMP: begin
              if (occ == '0) begin
                res_q_next = make_res(ST_EMPTY, 1'b0, '0, '0, 1'b1);
                state_next = S_SEND;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = CW'(1);
                pend_next  = 1'b1;
                state_next = S_DUMP;
              end
            end
            default: begin
              res_q_next = make_res(ST_OK, 1'b0, '0, TALLY_W'(occ), 1'b1);
              state_next = S_SEND;
            end
          endcase
        end
      end

      // write target dpos+1 was read earlier; next read is dpos-1, so no overlap
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = AW'(dpos + 1'b1);
        if (rd_data > val) begin
          wr_data = rd_data;
          if (dpos == '0) begin
            state_next = S_INS0;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = AW'(dpos - 1'b1);
            dpos_next = dpos - 1'b1;
          end
        end else begin
          wr_data    = val;
          occ_next   = occ + 1'b1;
          res_q_next = make_res(ST_OK, 1'b0, '0, TALLY_W'(occ + 1'b1), 1'b1);
          state_next = S_SEND;
        end
      end

      S_INS0: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = val;
        occ_next   = occ + 1'b1;
        res_q_next = make_res(ST_OK, 1'b0, '0, TALLY_W'(occ + 1'b1), 1'b1);
        state_next = S_SEND;
      end

      // upward scan; remove pulls every entry past the first match down by one
      S_UP: begin
        hit_next   = hit_n;
        evens_next = evens_n;
        if ((op == FUNC_REMOVE) && hit) begin
          wr_en   = 1'b1;
          wr_addr = AW'(dpos - 1'b1);
          wr_data = rd_data;
        end
        if (dpos == occ - 1'b1) begin
          state_next = S_SEND;
          case (op)
            FUNC_REMOVE: begin
              if (hit_n) begin
                occ_next   = occ - 1'b1;
                res_q_next = make_res(ST_OK, 1'b0, '0, TALLY_W'(occ - 1'b1), 1'b1);
              end else begin
                res_q_next = make_res(ST_NOTFOUND, 1'b0, '0, TALLY_W'(occ), 1'b1);
              end
            end
            FUNC_SEARCH: begin
              res_q_next = make_res(ST_OK, hit_n, '0, TALLY_W'(occ), 1'b1);
            end
            default: begin
              res_q_next = make_res(ST_OK, 1'b0, '0, TALLY_W'(evens_n), 1'b1);
            end
          endcase
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(dpos + 1'b1);
          dpos_next = dpos + 1'b1;
        end
      end

      S_DUMP: begin
        if (issue) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(idx);
          idx_next = idx + 1'b1;
        end
        pend_next = issue || (pend && !can_load);
        if (can_load && (idx == occ)) begin
          state_next = S_IDLE;
        end
      end

      S_SEND: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_SEND) || ((state == S_DUMP) && pend);
  assign res = (state == S_DUMP)
             ? make_res(ST_OK, 1'b0, rd_data, TALLY_W'(occ), idx == occ)
             : res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    dpos  <= dpos_next;
    idx   <= idx_next;
    evens <= evens_next;
    hit   <= hit_next;
    op    <= op_next;
    val   <= val_next;
    res_q <= res_q_next;
  end

endmodule

`default_nettype wire

>>> rtl/sorted_value_table_core.sv
// Top level of the sorted value table: sequencer, entry memory and result register.
`default_nettype none

// Holds up to DEPTH signed 32-bit values in ascending order (duplicates kept,
// a new equal value goes after the old ones) in a single-port-read,
// single-port-write memory with registered read data. One request is
// worked at a time. With n entries held, insert makes one memory read per
// entry walked down from the tail, remove, search and count make one read
// per entry walked up from the head, and every other case needs no scan;
// each result then passes through the output register. Dump streams n
// results at one per cycle while the result side keeps up. The memory read
// port paces these scans. No clearing pass is needed after reset; only the
// occupancy count, the sequencer state and the valid flags are cleared.
module sorted_value_table_core #(
  parameter int DEPTH = svt_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  svt_req_if.sink   req,
  svt_rsp_if.source rsp
);
  import svt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  value_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  value_t        wr_data;
  logic          res_valid;
  logic          res_ready;
  svt_res_t      res;

  svt_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_func  (req.func),
    .req_value (req.value),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  svt_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: takes a new result whenever it is empty or being drained
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.status <= res.status;
      rsp.found  <= res.found;
      rsp.entry  <= res.entry;
      rsp.tally  <= res.tally;
      rsp.last   <= res.last;
    end
  end

endmodule

`default_nettype wire
